### rtl/ptme_pkg.sv
`default_nettype none

package ptme_pkg;

    // Pool geometry. PAGE_W and NFP_W follow from the pool size, ADDR_W from PAGE_W and IDX_W.
    localparam int POOL_PAGES = 16;
    localparam int PAGE_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int NFP_W      = $clog2(POOL_PAGES + 1);
    localparam int IDX_W      = 9;
    localparam int ADDR_W     = PAGE_W + IDX_W;

    // Fixed field widths.
    localparam int PFN_W      = 36;
    localparam int VA_W       = 48;
    localparam int PA_W       = 64;
    localparam int DESC_W     = 64;
    localparam int STATUS_W   = 2;
    localparam int PUSED_W    = 5;
    localparam int PAGE_SH    = 12;

    // Descriptor attribute bits.
    localparam logic [DESC_W-1:0] DESC_TABLE = 64'h0000_0000_0000_0403;
    localparam logic [DESC_W-1:0] DESC_BLOCK = 64'h0000_0000_0000_0401;
    localparam logic [DESC_W-1:0] DESC_PAGE  = 64'h0000_0000_0000_0407;

    // Second block entry of the level-2 table written by init.
    localparam logic [IDX_W-1:0] BLOCK_IDX_HI = 9'd128;

    localparam logic [PFN_W-1:0] POOL_BASE_RESET = 36'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_INIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

    // Request kinds.
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    // Operation for the shared frame-number unit.
    typedef struct packed {
        logic             sub;   // 1: a - base (pool-relative index), 0: a + base
        logic [PFN_W-1:0] a;
    } pfn_op_t;

    typedef struct packed {
        logic [PFN_W-1:0] res;
        logic             in_pool; // res names an already allocated page
    } pfn_res_t;

    // Nine-bit table index of a virtual address for walk levels 0 to 3.
    function automatic logic [IDX_W-1:0] va_slice(input logic [VA_W-1:0] va,
                                                  input logic [1:0] level);
        logic [IDX_W-1:0] s;
        case (level)
            2'd0:    s = va[47:39];
            2'd1:    s = va[38:30];
            2'd2:    s = va[29:21];
            default: s = va[20:12];
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/page_table_map_engine_core.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tuser: kind; tdata: vaddr, paddr
// m_        out        m_tvalid/m_tready    tdata: status, root, leaf table, entry, pages used
// cfg_      in         cfg_valid/cfg_ready  cfg_data: pool_base_page
//
// One request is in flight at a time; s_tready is high only while the sequencer idles.
// A map walks the tables from the root, reading and checking one entry per level, then writes
// the leaf entry. Each missing table adds a clear sweep of the next free page and a link write.
// Init clears three pages, then latches the root and writes two links and two block entries.
// Reset clears the sequencer, root, free-page count and init flag, not the table store; a
// stalled m_tready holds the next result in the done state, and the input waits behind it.
module page_table_map_engine_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [111:0]  s_tdata,   // [47:0] vaddr, [111:48] paddr
    input  wire logic [0:0]    s_tuser,   // [0] kind

    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [167:0]       m_tdata,   // [1:0] status, [49:2] root_addr,
                                          // [97:50] leaf_table_addr,
                                          // [161:98] entry_written,
                                          // [166:162] pages_used, [167] zero

    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [35:0]   cfg_data   // [35:0] pool_base_page
);

    localparam int PAGE_W = ptme_pkg::PAGE_W;
    localparam int NFP_W  = ptme_pkg::NFP_W;
    localparam int IDX_W  = ptme_pkg::IDX_W;
    localparam int ADDR_W = ptme_pkg::ADDR_W;
    localparam int PFN_W  = ptme_pkg::PFN_W;
    localparam int VA_W   = ptme_pkg::VA_W;
    localparam int DESC_W = ptme_pkg::DESC_W;
    localparam int DEPTH  = ptme_pkg::POOL_PAGES * (2 ** IDX_W);

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ROOT      = 4'd1;
    localparam logic [3:0] S_WALK_RD   = 4'd2;
    localparam logic [3:0] S_WALK_CHK  = 4'd3;
    localparam logic [3:0] S_ALLOC_CHK = 4'd4;
    localparam logic [3:0] S_CLEAR     = 4'd5;
    localparam logic [3:0] S_MAP_LINK  = 4'd6;
    localparam logic [3:0] S_LEAF      = 4'd7;
    localparam logic [3:0] S_INIT_WR   = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    // Control registers.
    logic [3:0]        state_reg, state_next;
    logic [NFP_W-1:0]  nfp_reg, nfp_next;
    logic [PFN_W-1:0]  root_reg, root_next;
    logic              init_done_reg, init_done_next;
    logic [PFN_W-1:0]  base_reg;
    logic              m_valid_reg, m_valid_next;

    // Per-request working registers.
    logic                      kind_reg, kind_next;
    logic [VA_W-1:0]           va_reg, va_next;
    logic [ptme_pkg::PA_W-1:0] pa_reg, pa_next;
    logic [1:0]                level_reg, level_next;
    logic [PAGE_W-1:0]         cur_reg, cur_next;
    logic [IDX_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [2:0]                sub_reg, sub_next;
    logic [ptme_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [VA_W-1:0]           leaf_reg, leaf_next;
    logic [DESC_W-1:0]         entry_reg, entry_next;

    // Output register.
    logic [167:0]      out_reg, out_next;

    // Table store.
    logic [DESC_W-1:0] store_mem [DEPTH];
    logic [DESC_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DESC_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;

    // Shared frame-number unit.
    ptme_pkg::pfn_op_t  pfn_op;
    ptme_pkg::pfn_res_t pfn_res;

    ptme_pfn_unit u_pfn (
        .op   (pfn_op),
        .base (base_reg),
        .nfp  (nfp_reg),
        .res  (pfn_res)
    );

    // Init works on three consecutive pages starting at cur_reg. During the
    // clear sweep sub_reg selects the page; during the link writes it selects
    // the step, where the last two steps both land in the level-2 table.
    logic [PAGE_W-1:0] init_page;
    logic [1:0]        init_off;
    logic [NFP_W:0]    free_pages;
    logic [1:0]        need_pages;
    logic [PAGE_W-1:0] clr_page;
    logic [DESC_W-1:0] link_desc;

    always_comb begin
        if (state_reg == S_CLEAR) begin
            init_off = sub_reg[1:0];
        end else begin
            case (sub_reg)
                3'd0:    init_off = 2'd0;
                3'd1:    init_off = 2'd1;
                default: init_off = 2'd2;
            endcase
        end
    end

    assign init_page  = cur_reg + PAGE_W'(init_off);
    assign free_pages = (NFP_W + 1)'(ptme_pkg::POOL_PAGES) - (NFP_W + 1)'(nfp_reg);
    assign need_pages = 2'd3 - level_reg;
    assign clr_page   = (kind_reg == ptme_pkg::KIND_INIT) ? init_page
                                                          : nfp_reg[PAGE_W-1:0];
    // Table descriptor pointing at the frame from the shared unit.
    assign link_desc  = {{(DESC_W - PFN_W - ptme_pkg::PAGE_SH){1'b0}},
                         pfn_res.res, {ptme_pkg::PAGE_SH{1'b0}}} | ptme_pkg::DESC_TABLE;

    assign rd_addr = {cur_reg, ptme_pkg::va_slice(va_reg, level_reg)};

    // Operand select for the shared unit.
    always_comb begin
        pfn_op.sub = 1'b0;
        pfn_op.a   = PFN_W'(cur_reg);
        case (state_reg)
            S_ROOT: begin
                pfn_op.sub = 1'b1;
                pfn_op.a   = root_reg;
            end
            S_WALK_CHK: begin
                pfn_op.sub = 1'b1;
                pfn_op.a   = rd_data_reg[47:12];
            end
            S_INIT_WR: begin
                pfn_op.a = PFN_W'(init_page);
            end
            S_MAP_LINK: begin
                pfn_op.a = PFN_W'(nfp_reg);
            end
            default: begin
                pfn_op.a = PFN_W'(cur_reg);
            end
        endcase
    end

    // Store write port.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {clr_page, clr_cnt_reg};
        wr_data = '0;
        case (state_reg)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_MAP_LINK: begin
                wr_en   = 1'b1;
                wr_addr = rd_addr;
                wr_data = link_desc;
            end
            S_LEAF: begin
                wr_en   = 1'b1;
                wr_addr = {cur_reg, va_reg[20:12]};
                wr_data = pa_reg | ptme_pkg::DESC_PAGE;
            end
            S_INIT_WR: begin
                // Step 0 only latches the root; the rest write links and blocks.
                wr_en   = (sub_reg != 3'd0);
                wr_addr = {cur_reg + PAGE_W'(init_off - 2'd1), {IDX_W{1'b0}}};
                wr_data = link_desc;
                if (sub_reg == 3'd3) begin
                    wr_addr = {init_page, {IDX_W{1'b0}}};
                    wr_data = ptme_pkg::DESC_BLOCK;
                end else if (sub_reg == 3'd4) begin
                    wr_addr = {init_page, ptme_pkg::BLOCK_IDX_HI};
                    wr_data = ptme_pkg::DESC_BLOCK;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        nfp_next       = nfp_reg;
        root_next      = root_reg;
        init_done_next = init_done_reg;
        m_valid_next   = m_valid_reg;
        kind_next      = kind_reg;
        va_next        = va_reg;
        pa_next        = pa_reg;
        level_next     = level_reg;
        cur_next       = cur_reg;
        clr_cnt_next   = clr_cnt_reg;
        sub_next       = sub_reg;
        status_next    = status_reg;
        leaf_next      = leaf_reg;
        entry_next     = entry_reg;
        out_next       = out_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = s_tuser[0];
                    va_next      = s_tdata[47:0];
                    pa_next      = s_tdata[111:48];
                    status_next  = ptme_pkg::ST_OK;
                    leaf_next    = '0;
                    entry_next   = '0;
                    level_next   = 2'd0;
                    sub_next     = 3'd0;
                    clr_cnt_next = '0;
                    cur_next     = nfp_reg[PAGE_W-1:0];
                    if (s_tuser[0] == ptme_pkg::KIND_INIT) begin
                        if (free_pages < (NFP_W + 1)'(3)) begin
                            status_next = ptme_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_CLEAR;
                        end
                    end else if (!init_done_reg) begin
                        status_next = ptme_pkg::ST_NO_INIT;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (pfn_res.in_pool) begin
                    cur_next   = pfn_res.res[PAGE_W-1:0];
                    state_next = S_WALK_RD;
                end else begin
                    status_next = ptme_pkg::ST_OUTSIDE;
                    state_next  = S_DONE;
                end
            end
            S_WALK_RD: begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (!rd_data_reg[0]) begin
                    state_next = S_ALLOC_CHK;
                end else if (!pfn_res.in_pool) begin
                    status_next = ptme_pkg::ST_OUTSIDE;
                    state_next  = S_DONE;
                end else begin
                    cur_next   = pfn_res.res[PAGE_W-1:0];
                    level_next = level_reg + 2'd1;
                    state_next = (level_reg == 2'd2) ? S_ALLOC_CHK : S_WALK_RD;
                end
            end
            S_ALLOC_CHK: begin
                clr_cnt_next = '0;
                if (free_pages < (NFP_W + 1)'(need_pages)) begin
                    status_next = ptme_pkg::ST_FULL;
                    state_next  = S_DONE;
                end else if (level_reg == 2'd3) begin
                    state_next = S_LEAF;
                end else begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == {IDX_W{1'b1}}) begin
                    if (kind_reg == ptme_pkg::KIND_INIT) begin
                        if (sub_reg == 3'd2) begin
                            sub_next   = 3'd0;
                            state_next = S_INIT_WR;
                        end else begin
                            sub_next = sub_reg + 3'd1;
                        end
                    end else begin
                        state_next = S_MAP_LINK;
                    end
                end
            end
            S_MAP_LINK: begin
                // Link the freshly cleared page into the current table.
                cur_next     = nfp_reg[PAGE_W-1:0];
                nfp_next     = nfp_reg + NFP_W'(1);
                level_next   = level_reg + 2'd1;
                clr_cnt_next = '0;
                state_next   = (level_reg == 2'd2) ? S_LEAF : S_CLEAR;
            end
            S_LEAF: begin
                leaf_next  = {pfn_res.res, {ptme_pkg::PAGE_SH{1'b0}}};
                entry_next = pa_reg | ptme_pkg::DESC_PAGE;
                state_next = S_DONE;
            end
            S_INIT_WR: begin
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd0) begin
                    root_next = pfn_res.res;
                end
                if (sub_reg == 3'd4) begin
                    init_done_next = 1'b1;
                    nfp_next       = nfp_reg + NFP_W'(3);
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_next = {1'b0,
                                ptme_pkg::PUSED_W'(nfp_reg),
                                entry_reg,
                                leaf_reg,
                                root_reg, {ptme_pkg::PAGE_SH{1'b0}},
                                status_reg};
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            nfp_reg       <= '0;
            root_reg      <= '0;
            init_done_reg <= 1'b0;
            base_reg      <= ptme_pkg::POOL_BASE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            nfp_reg       <= nfp_next;
            root_reg      <= root_next;
            init_done_reg <= init_done_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        va_reg      <= va_next;
        pa_reg      <= pa_next;
        level_reg   <= level_next;
        cur_reg     <= cur_next;
        clr_cnt_reg <= clr_cnt_next;
        sub_reg     <= sub_next;
        status_reg  <= status_next;
        leaf_reg    <= leaf_next;
        entry_reg   <= entry_next;
        out_reg     <= out_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

### rtl/ptme_pfn_unit.sv
`default_nettype none

// Shared 36-bit frame-number adder. Turns pool page indexes into frame
// numbers and frame numbers back into pool-relative indexes, with the
// check that the index names a page already handed out.
module ptme_pfn_unit (
    input  wire ptme_pkg::pfn_op_t               op,
    input  wire logic [ptme_pkg::PFN_W-1:0]      base,
    input  wire logic [ptme_pkg::NFP_W-1:0]      nfp,
    output ptme_pkg::pfn_res_t                   res
);

    logic [ptme_pkg::PFN_W-1:0] b_opnd;
    logic [ptme_pkg::PFN_W-1:0] sum;

    assign b_opnd = op.sub ? ~base : base;
    assign sum    = op.a + b_opnd + ptme_pkg::PFN_W'(op.sub);

    assign res.res     = sum;
    assign res.in_pool = (sum < ptme_pkg::PFN_W'(nfp));

endmodule

`default_nettype wire
